FILE: hw/rtl/srb_pkg.sv
// Shared types and codes for the sequence reorder buffer.
`default_nettype none
package srb_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_RELEASED = 2'd0,
    ST_PARKED   = 2'd1,
    ST_STALE    = 2'd2,
    ST_BEYOND   = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    SRB_IDLE  = 2'd0,
    SRB_EVAL  = 2'd1,
    SRB_DRAIN = 2'd2
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic eval;
    logic drain;
  } srb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cont;
  } srb_stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/srb_ctrl.sv
// Controller state machine of the sequence reorder buffer.
`default_nettype none
module srb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire srb_pkg::srb_stat_t stat,
  output srb_pkg::srb_cmd_t      cmd,
  output logic                   busy
);

  srb_pkg::state_t state_r, state_nxt;

  // Hold the state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srb_pkg::SRB_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Decode next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      srb_pkg::SRB_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = srb_pkg::SRB_EVAL;
        end
      end
      srb_pkg::SRB_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = stat.cont ? srb_pkg::SRB_DRAIN : srb_pkg::SRB_IDLE;
      end
      srb_pkg::SRB_DRAIN: begin
        cmd.drain = 1'b1;
        state_nxt = stat.cont ? srb_pkg::SRB_DRAIN : srb_pkg::SRB_IDLE;
      end
      default: begin
        state_nxt = srb_pkg::SRB_IDLE;
      end
    endcase
  end

  // Drain is only reached from evaluation or from itself.
  a_drain_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == srb_pkg::SRB_DRAIN) |->
      ($past(state_r) == srb_pkg::SRB_EVAL || $past(state_r) == srb_pkg::SRB_DRAIN))
    else $error("drain entered from idle");

  // A load always moves the controller to evaluation.
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == srb_pkg::SRB_EVAL))
    else $error("load did not move to evaluation");

endmodule
`default_nettype wire

FILE: hw/rtl/srb_dp.sv
// Datapath of the sequence reorder buffer: counter, slot store and result register.
`default_nettype none
module srb_dp #(
  parameter int WINDOW_SLOTS = 32,
  parameter int TAG_BITS     = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire srb_pkg::srb_cmd_t       cmd,
  output srb_pkg::srb_stat_t           stat,
  input  wire logic [63:0]             in_sequence_number,
  input  wire logic [TAG_BITS-1:0]     in_payload_tag,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic [TAG_BITS-1:0]          out_released_tag,
  output logic [63:0]                  out_released_sequence,
  output logic                         out_last_of_run
);

  localparam int IDXW = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
  localparam int CW   = $clog2(WINDOW_SLOTS + 1);
  localparam logic [IDXW-1:0] IDX_LAST  = IDXW'(WINDOW_SLOTS - 1);
  localparam logic [IDXW:0]   SLOTS_EXT = (IDXW + 1)'(WINDOW_SLOTS);
  localparam logic [CW-1:0]   SLOTS_CNT = CW'(WINDOW_SLOTS);

  // Item and counter registers.
  logic [63:0]             seq_r;
  logic [TAG_BITS-1:0]     tag_r;
  logic [63:0]             exp_r, exp_nxt;
  logic [IDXW-1:0]         idx_r, idx_nxt;
  logic [WINDOW_SLOTS-1:0] occ_r, occ_nxt;
  logic [CW-1:0]           n_r, n_nxt;
  logic [TAG_BITS-1:0]     rd_tag_r;
  logic [TAG_BITS-1:0]     tag_mem [WINDOW_SLOTS];

  // Result register.
  logic                    valid_r, valid_nxt;
  srb_pkg::status_t        status_r, status_nxt;
  logic [TAG_BITS-1:0]     otag_r, otag_nxt;
  logic [63:0]             oseq_r, oseq_nxt;
  logic                    last_r, last_nxt;

  // Compare and window arithmetic.
  logic                    is_eq, is_gt, in_win, park;
  logic [63:0]             gap;
  logic [63:0]             exp_inc;
  logic [IDXW-1:0]         idx_inc;
  logic                    occ_next;
  logic [IDXW:0]           park_sum;
  logic [IDXW-1:0]         park_idx;
  logic [CW-1:0]           n_plus;

  assign is_eq   = (seq_r == exp_r);
  assign is_gt   = (seq_r > exp_r);
  assign gap     = seq_r - exp_r;
  assign in_win  = (gap <= 64'(WINDOW_SLOTS - 1));
  assign park    = is_gt && in_win;
  assign exp_inc = exp_r + 64'd1;
  // Counter wrap resets the slot index to zero along with the counter.
  assign idx_inc = ((exp_r == '1) || (idx_r == IDX_LAST)) ? '0 : idx_r + IDXW'(1);
  assign occ_next = occ_r[idx_inc];
  assign park_sum = {1'b0, idx_r} + {1'b0, gap[IDXW-1:0]};
  assign park_idx = (park_sum >= SLOTS_EXT) ? IDXW'(park_sum - SLOTS_EXT)
                                            : park_sum[IDXW-1:0];
  assign n_plus   = n_r + CW'(1);

  // Decide whether another drained result follows this one.
  always_comb begin
    stat.cont = 1'b0;
    if (cmd.eval) begin
      stat.cont = is_eq && occ_next;
    end else if (cmd.drain) begin
      stat.cont = occ_next && (n_plus < SLOTS_CNT);
    end
  end

  // Compute next counter, occupancy and result.
  always_comb begin
    exp_nxt    = exp_r;
    idx_nxt    = idx_r;
    occ_nxt    = occ_r;
    n_nxt      = n_r;
    valid_nxt  = 1'b0;
    status_nxt = status_r;
    otag_nxt   = otag_r;
    oseq_nxt   = oseq_r;
    last_nxt   = last_r;
    if (cmd.eval) begin
      valid_nxt = 1'b1;
      oseq_nxt  = seq_r;
      otag_nxt  = '0;
      last_nxt  = !stat.cont;
      if (is_eq) begin
        status_nxt = srb_pkg::ST_RELEASED;
        otag_nxt   = tag_r;
        exp_nxt    = exp_inc;
        idx_nxt    = idx_inc;
        n_nxt      = CW'(1);
      end else if (park) begin
        status_nxt          = srb_pkg::ST_PARKED;
        occ_nxt[park_idx]   = 1'b1;
      end else if (is_gt) begin
        status_nxt = srb_pkg::ST_BEYOND;
      end else begin
        status_nxt = srb_pkg::ST_STALE;
      end
    end else if (cmd.drain) begin
      valid_nxt       = 1'b1;
      status_nxt      = srb_pkg::ST_RELEASED;
      otag_nxt        = rd_tag_r;
      oseq_nxt        = exp_r;
      last_nxt        = !stat.cont;
      occ_nxt[idx_r]  = 1'b0;
      exp_nxt         = exp_inc;
      idx_nxt         = idx_inc;
      n_nxt           = n_plus;
    end
  end

  // Hold control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r   <= 64'd1;
      idx_r   <= IDXW'(1 % WINDOW_SLOTS);
      occ_r   <= '0;
      n_r     <= '0;
      valid_r <= 1'b0;
    end else begin
      exp_r   <= exp_nxt;
      idx_r   <= idx_nxt;
      occ_r   <= occ_nxt;
      n_r     <= n_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Capture the beat and the result payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      seq_r <= in_sequence_number;
      tag_r <= in_payload_tag;
    end
    status_r <= status_nxt;
    otag_r   <= otag_nxt;
    oseq_r   <= oseq_nxt;
    last_r   <= last_nxt;
  end

  // Slot tag store: write on park, read ahead at the next expected slot.
  always_ff @(posedge clk) begin
    if (cmd.eval && park) begin
      tag_mem[park_idx] <= tag_r;
    end
    rd_tag_r <= tag_mem[idx_inc];
  end

  assign out_valid             = valid_r;
  assign out_status            = status_r;
  assign out_released_tag      = otag_r;
  assign out_released_sequence = oseq_r;
  assign out_last_of_run       = last_r;

  // Anything other than a release ends the run.
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && status_r != srb_pkg::ST_RELEASED) |-> last_r)
    else $error("non-release result not last of run");

  // A drain step frees the slot it delivered.
  a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drain |=> !occ_r[$past(idx_r)])
    else $error("drained slot still occupied");

  // The result count of one item never passes the window size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= SLOTS_CNT)
    else $error("result count beyond window");

endmodule
`default_nettype wire

FILE: hw/rtl/sequence_reorder_buffer.sv
// Top level of the sequence reorder buffer.
// Each item is taken when start is high and busy is low; its first result
// appears on the out_ ports for one cycle, with out_valid. A parked, stale
// or beyond-window item and a release with nothing to drain give a single
// result; every parked successor drained after a release adds one result,
// and out_last_of_run marks the final result of the item. busy drops in the
// cycle the final result is shown, so the next item can be taken while it is
// delivered. The drain rate is set by the registered read of the slot tag
// memory, which is addressed one slot ahead. Results cannot be held off by
// the receiver. The slot occupancy bits clear at reset, so no clearing pass
// follows reset.
`default_nettype none
module sequence_reorder_buffer #(
  parameter int WINDOW_SLOTS = 32,
  parameter int TAG_BITS     = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [63:0]         in_sequence_number,
  input  wire logic [TAG_BITS-1:0] in_payload_tag,
  output logic                     out_valid,
  output logic [1:0]               out_status,
  output logic [TAG_BITS-1:0]      out_released_tag,
  output logic [63:0]              out_released_sequence,
  output logic                     out_last_of_run
);

  srb_pkg::srb_cmd_t  cmd;
  srb_pkg::srb_stat_t stat;

  // Sequence the work of each item.
  srb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Hold the counter and slots, form the results.
  srb_dp #(
    .WINDOW_SLOTS (WINDOW_SLOTS),
    .TAG_BITS     (TAG_BITS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .stat                  (stat),
    .in_sequence_number    (in_sequence_number),
    .in_payload_tag        (in_payload_tag),
    .out_valid             (out_valid),
    .out_status            (out_status),
    .out_released_tag      (out_released_tag),
    .out_released_sequence (out_released_sequence),
    .out_last_of_run       (out_last_of_run)
  );

  // A result strobe only follows work started by an accepted beat.
  a_valid_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without work in progress");

endmodule
`default_nettype wire

FILE: tb/sequence_reorder_buffer_tb.sv
// Self-checking testbench for the sequence reorder buffer: predicted in-order release vs. DUT.
module sequence_reorder_buffer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW_SLOTS  = 32;
  localparam int TAG_BITS      = 16;
  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 6;
  localparam int RANDOM_ITEMS  = 100;
  localparam int CALM_ITEMS    = 20;
  localparam int MAX_REPORTS   = 10;
  localparam int DRAIN_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 2 * WINDOW_SLOTS + 8;
  localparam longint TIMEOUT_NS = 2_000_000;

  // One result beat as the block should present it.
  typedef struct {
    srb_pkg::status_t    status;
    logic [TAG_BITS-1:0] tag;
    logic [63:0]         seq;
    logic                last;
  } delivery_t;

  // Tracks the in-order release state and the queue of results still owed.
  class release_order_checker;
    logic [63:0]         next_seq;
    bit                  parked   [WINDOW_SLOTS];
    logic [TAG_BITS-1:0] slot_tag [WINDOW_SLOTS];
    delivery_t           owed[$];
    int                  mismatches;
    int                  deliveries;
    int                  arrivals;
    int                  longest_run;
    int                  status_seen [4];

    function new();
      next_seq = 64'd1;
      foreach (parked[i]) begin
        parked[i]   = 1'b0;
        slot_tag[i] = '0;
      end
      foreach (status_seen[i]) status_seen[i] = 0;
      mismatches  = 0;
      deliveries  = 0;
      arrivals    = 0;
      longest_run = 0;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("[%0t] MISMATCH: %s", $time, msg);
    endfunction

    // Predict every result caused by one accepted input beat.
    function void note_arrival(logic [63:0] seq, logic [TAG_BITS-1:0] tag);
      delivery_t   run[$];
      int          idx;
      logic [63:0] gap;
      arrivals++;
      if (seq == next_seq) begin
        run.push_back(delivery_t'{srb_pkg::ST_RELEASED, tag, seq, 1'b0});
        next_seq = next_seq + 64'd1;
        idx = int'(next_seq % WINDOW_SLOTS);
        // drain parked successors that are now next in line
        while (parked[idx] && run.size() < WINDOW_SLOTS) begin
          run.push_back(delivery_t'{srb_pkg::ST_RELEASED, slot_tag[idx],
                                    next_seq, 1'b0});
          parked[idx] = 1'b0;
          next_seq = next_seq + 64'd1;
          idx = int'(next_seq % WINDOW_SLOTS);
        end
      end else if (seq > next_seq) begin
        gap = seq - next_seq;
        if (gap <= 64'(WINDOW_SLOTS - 1)) begin
          idx = int'(seq % WINDOW_SLOTS);
          slot_tag[idx] = tag;
          parked[idx]   = 1'b1;
          run.push_back(delivery_t'{srb_pkg::ST_PARKED, '0, seq, 1'b0});
        end else begin
          run.push_back(delivery_t'{srb_pkg::ST_BEYOND, '0, seq, 1'b0});
        end
      end else begin
        run.push_back(delivery_t'{srb_pkg::ST_STALE, '0, seq, 1'b0});
      end
      run[run.size()-1].last = 1'b1;
      if (run.size() > longest_run) longest_run = run.size();
      foreach (run[i]) begin
        status_seen[run[i].status]++;
        owed.push_back(run[i]);
      end
    endfunction

    // Compare one result beat with the oldest owed result.
    function void check_delivery(logic [1:0] st, logic [TAG_BITS-1:0] tag,
                                 logic [63:0] seq, logic last);
      delivery_t want;
      deliveries++;
      if (owed.size() == 0) begin
        flag($sformatf("unexpected result status=%0d tag=%h seq=%h last=%b",
                       st, tag, seq, last));
      end else begin
        want = owed.pop_front();
        if (st !== want.status || tag !== want.tag || seq !== want.seq ||
            last !== want.last)
          flag($sformatf({"expected status=%0d tag=%h seq=%h last=%b, ",
                          "got status=%0d tag=%h seq=%h last=%b"},
                         want.status, want.tag, want.seq, want.last,
                         st, tag, seq, last));
      end
    endfunction

    // Count results that never showed up.
    function void close_out();
      if (owed.size() != 0)
        flag($sformatf("%0d results never delivered, oldest seq=%h",
                       owed.size(), owed[0].seq));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [63:0]         in_sequence_number = '0;
  logic [TAG_BITS-1:0] in_payload_tag = '0;
  logic                out_valid;
  logic [1:0]          out_status;
  logic [TAG_BITS-1:0] out_released_tag;
  logic [63:0]         out_released_sequence;
  logic                out_last_of_run;

  release_order_checker ledger = new();
  int items_sent     = 0;
  int directed_items = 0;
  int calm_after     = 1 << 30;
  int random_stop    = 0;
  int pick;
  int wait_cycles;

  sequence_reorder_buffer #(
    .WINDOW_SLOTS(WINDOW_SLOTS),
    .TAG_BITS    (TAG_BITS)
  ) i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_sequence_number   (in_sequence_number),
    .in_payload_tag       (in_payload_tag),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_released_tag     (out_released_tag),
    .out_released_sequence(out_released_sequence),
    .out_last_of_run      (out_last_of_run)
  );

  always #(CLK_HALF) clk = ~clk;

  // Check every result beat at the edge that ends its cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      ledger.check_delivery(out_status, out_released_tag, out_released_sequence,
                            out_last_of_run);
  end

  // Hold one beat on the input until the block takes it.
  task automatic send_item(logic [63:0] seq, logic [TAG_BITS-1:0] tag);
    start              <= 1'b1;
    in_sequence_number <= seq;
    in_payload_tag     <= tag;
    do @(posedge clk); while (busy !== 1'b0);
    ledger.note_arrival(seq, tag);
  endtask

  // Drop start for a while, with junk on the data ports.
  task automatic idle_for(int cycles);
    start              <= 1'b0;
    in_sequence_number <= {$urandom, $urandom};
    in_payload_tag     <= TAG_BITS'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  // Send one beat, sometimes after an idle burst.
  task automatic offer(logic [63:0] seq, logic [TAG_BITS-1:0] tag);
    if (items_sent < calm_after && $urandom_range(0, 3) == 0)
      idle_for($urandom_range(1, 6));
    send_item(seq, tag);
    items_sent++;
  endtask

  // Send a shuffled run of consecutive numbers from the expected one; head may be dropped.
  task automatic send_block(int span, bit drop_head, bit head_last, bit add_repeat);
    logic [63:0] base;
    int          order[$];
    int          j;
    int          tmp;
    base = ledger.next_seq;
    for (int i = 1; i < span; i++) order.push_back(i);
    for (int i = order.size() - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    if (!drop_head) begin
      if (head_last) order.push_back(0);
      else order.insert($urandom_range(0, order.size()), 0);
    end
    if (add_repeat && order.size() > 0)
      order.insert($urandom_range(0, order.size()),
                   order[$urandom_range(0, order.size() - 1)]);
    foreach (order[i]) offer(base + 64'(order[i]), TAG_BITS'($urandom));
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, window edges, repeat, stale, drain.
    offer(64'd0, 16'hFFFF);                     // zero sequence is stale
    offer(64'hFFFF_FFFF_FFFF_FFFF, 16'h0000);   // far beyond the window
    offer(64'h8000_0000_0000_0000, 16'h5A5A);
    offer(64'd33, 16'hA5A5);                    // one past the window edge
    offer(64'd32, 16'h0001);                    // last slot of the window
    offer(64'd3, 16'h1111);
    offer(64'd3, 16'h2222);                     // repeat overwrites the slot
    offer(64'd4, 16'hFFFF);
    offer(64'd5, 16'h0000);
    offer(64'd1, 16'hFFFF);                     // release, nothing to drain
    offer(64'd2, 16'h0000);                     // release and drain 3..5
    offer(64'd1, 16'h7FFF);                     // below expected
    offer(64'd5, 16'h8000);                     // already delivered
    offer(64'd6, 16'h00FF);
    offer(64'd38, 16'hFF00);                    // window edge again
    offer(64'd39, 16'h1234);
    offer(64'd8, 16'hBEEF);
    offer(64'd7, 16'hCAFE);                     // release and drain 8
    directed_items = items_sent;
    random_stop    = items_sent + RANDOM_ITEMS;
    calm_after     = random_stop - CALM_ITEMS;

    // Rest of the window parked, then the head: longest possible drain.
    send_block(WINDOW_SLOTS, 1'b0, 1'b1, 1'b0);

    // Random: mostly well-formed runs, some broken runs and noise.
    while (items_sent < random_stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)
        send_block($urandom_range(1, 8), 1'b0, $urandom_range(0, 3) == 0,
                   $urandom_range(0, 4) == 0);
      else if (pick < 60)
        send_block($urandom_range(16, WINDOW_SLOTS), 1'b0, $urandom_range(0, 1), 1'b0);
      else if (pick < 70)
        send_block($urandom_range(2, 10), 1'b1, 1'b0, $urandom_range(0, 3) == 0);
      else if (pick < 84)
        offer(64'($urandom_range(0, 32'(ledger.next_seq - 64'd1))), TAG_BITS'($urandom));
      else if (pick < 92)
        offer(ledger.next_seq + 64'(WINDOW_SLOTS) + 64'($urandom_range(0, 40)),
              TAG_BITS'($urandom));
      else
        offer({$urandom, $urandom}, TAG_BITS'($urandom));
    end
    start <= 1'b0;

    // Wait for the owed results, then let the block settle.
    wait_cycles = 0;
    while (ledger.owed.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    ledger.close_out();

    $display("Covered %0d input beats (%0d directed), %0d results, longest run %0d.",
             items_sent, directed_items, ledger.deliveries, ledger.longest_run);
    $display("Statuses: %0d released, %0d parked, %0d stale, %0d beyond window; %0d mismatches.",
             ledger.status_seen[srb_pkg::ST_RELEASED],
             ledger.status_seen[srb_pkg::ST_PARKED],
             ledger.status_seen[srb_pkg::ST_STALE],
             ledger.status_seen[srb_pkg::ST_BEYOND],
             ledger.mismatches);
    if (ledger.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hard stop if the run hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

endmodule
